// ----- rtl/lpg_pkg.sv -----
package lpg_pkg;

  // tile and field geometry
  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 32;
  localparam int RW_W      = 7;
  localparam int ERR_W     = COORD_W + 1;
  localparam int CNT_W     = COORD_W + 1;
  localparam int IDX_W     = COORD_W + RW_W + 1;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = CFG_IDX_W'(1);

  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = RW_W'(64);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_len;
    logic last_pixel;
  } lpg_status_t;

  // saturate a coordinate to the tile
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W:0] c;
    c = {1'b0, v};
    if (c >= (COORD_W+1)'(TILE_SIZE)) c = (COORD_W+1)'(TILE_SIZE - 1);
    return c[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/lpg_in_if.sv -----
interface lpg_in_if;
  import lpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic [COLOR_W-1:0] color;

  modport source (output valid, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, color, output ready);
endinterface

// ----- rtl/lpg_out_if.sv -----
interface lpg_out_if;
  import lpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                  output ready);
endinterface

// ----- rtl/lpg_cfg_if.sv -----
interface lpg_cfg_if;
  import lpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ----- rtl/line_pixel_generator_top.sv -----
// Line rasterizer: one line request in, its pixels out one per request.
// First pixel: the walk registers are loaded, then the result register.
// Throughput: one pixel per cycle from the Bresenham step unit, out_ready
// permitting; a line gives max(|dx|,|dy|) pixels, a zero-length line none.
// Reset: synchronous active-low; walk idle, frame_base 0, row_width 64.
module line_pixel_generator_top (
  input logic      clk,
  input logic      rst_n,
  lpg_in_if.sink   in_ch,
  lpg_out_if.source out_ch,
  lpg_cfg_if.sink  cfg_ch
);
  import lpg_pkg::*;

  lpg_cmd_t    cmd;
  lpg_status_t status;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpg_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .x_start       (in_ch.x_start),
    .y_start       (in_ch.y_start),
    .x_end         (in_ch.x_end),
    .y_end         (in_ch.y_end),
    .color         (in_ch.color),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.reg_index),
    .cfg_data      (cfg_ch.data),
    .pixel_x       (out_ch.pixel_x),
    .pixel_y       (out_ch.pixel_y),
    .pixel_address (out_ch.pixel_address),
    .pixel_color   (out_ch.pixel_color),
    .last          (out_ch.last),
    .status        (status)
  );

endmodule

// ----- rtl/lpg_datapath.sv -----
module lpg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpg_pkg::lpg_cmd_t             cmd,
  input  logic [lpg_pkg::COORD_W-1:0]   x_start,
  input  logic [lpg_pkg::COORD_W-1:0]   y_start,
  input  logic [lpg_pkg::COORD_W-1:0]   x_end,
  input  logic [lpg_pkg::COORD_W-1:0]   y_end,
  input  logic [lpg_pkg::COLOR_W-1:0]   color,
  input  logic                          cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpg_pkg::ADDR_W-1:0]    cfg_data,
  output logic [lpg_pkg::COORD_W-1:0]   pixel_x,
  output logic [lpg_pkg::COORD_W-1:0]   pixel_y,
  output logic [lpg_pkg::ADDR_W-1:0]    pixel_address,
  output logic [lpg_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last,
  output lpg_pkg::lpg_status_t          status
);
  import lpg_pkg::*;

  // configuration
  logic [ADDR_W-1:0] frame_base_r;
  logic [RW_W-1:0]   row_width_r;

  // walk state
  logic [COORD_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [COORD_W-1:0] major_r, minor_r, major_nxt, minor_nxt;
  logic               xneg_r, yneg_r, xmajor_r, xneg_nxt, yneg_nxt, xmajor_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic [COLOR_W-1:0] color_r;

  // output register
  logic [COORD_W-1:0] pixel_x_r, pixel_y_r;
  logic [ADDR_W-1:0]  pixel_address_r;
  logic [COLOR_W-1:0] pixel_color_r;
  logic               last_r;

  // command setup
  logic [COORD_W-1:0] xs, ys, xe, ye, adx, ady;
  logic [COORD_W:0]   dx_w, dy_w, dx_abs, dy_abs;
  logic               dx_neg, dy_neg, horiz, vert;

  always_comb begin
    xs = clamp_coord(x_start);
    ys = clamp_coord(y_start);
    xe = clamp_coord(x_end);
    ye = clamp_coord(y_end);
    dx_w = {1'b0, xe} - {1'b0, xs};
    dy_w = {1'b0, ye} - {1'b0, ys};
    dx_neg = dx_w[COORD_W];
    dy_neg = dy_w[COORD_W];
    dx_abs = dx_neg ? (~dx_w + 1'b1) : dx_w;
    dy_abs = dy_neg ? (~dy_w + 1'b1) : dy_w;
    adx = dx_abs[COORD_W-1:0];
    ady = dy_abs[COORD_W-1:0];
    horiz = (ady == '0);
    vert  = (adx == '0);

    // axis-aligned lines start one before the lesser end and walk upward
    if (horiz) begin
      px_nxt     = (dx_neg ? xe : xs) - COORD_W'(1);
      py_nxt     = ys;
      xneg_nxt   = 1'b0;
      yneg_nxt   = 1'b0;
      xmajor_nxt = 1'b1;
      major_nxt  = adx;
      minor_nxt  = '0;
    end else if (vert) begin
      px_nxt     = xs;
      py_nxt     = (dy_neg ? ye : ys) - COORD_W'(1);
      xneg_nxt   = 1'b0;
      yneg_nxt   = 1'b0;
      xmajor_nxt = 1'b0;
      major_nxt  = ady;
      minor_nxt  = '0;
    end else begin
      px_nxt     = xs;
      py_nxt     = ys;
      xneg_nxt   = dx_neg;
      yneg_nxt   = dy_neg;
      xmajor_nxt = (adx >= ady);
      major_nxt  = (adx >= ady) ? adx : ady;
      minor_nxt  = (adx >= ady) ? ady : adx;
    end
  end

  // one Bresenham step
  logic [ERR_W-1:0]   err_sum;
  logic               minor_step, x_move, y_move;
  logic [COORD_W-1:0] px_step, py_step;
  logic [IDX_W-1:0]   lin_idx;

  always_comb begin
    err_sum    = err_r + {1'b0, minor_r};
    minor_step = (err_sum >= {1'b0, major_r});
    err_nxt    = minor_step ? (err_sum - {1'b0, major_r}) : err_sum;
    x_move     = xmajor_r | minor_step;
    y_move     = ~xmajor_r | minor_step;
    px_step    = x_move ? (xneg_r ? px_r - COORD_W'(1) : px_r + COORD_W'(1)) : px_r;
    py_step    = y_move ? (yneg_r ? py_r - COORD_W'(1) : py_r + COORD_W'(1)) : py_r;
    left_nxt   = left_r - CNT_W'(1);
    lin_idx    = IDX_W'(py_step * row_width_r) + IDX_W'(px_step);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      row_width_r  <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_BASE: frame_base_r <= cfg_data;
        CFG_ROW_WIDTH:  row_width_r  <= cfg_data[RW_W-1:0];
        default: ;
      endcase
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cmd.load) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      err_r    <= {2'b00, major_nxt[COORD_W-1:1]};
      major_r  <= major_nxt;
      minor_r  <= minor_nxt;
      xneg_r   <= xneg_nxt;
      yneg_r   <= yneg_nxt;
      xmajor_r <= xmajor_nxt;
      left_r   <= {1'b0, major_nxt};
      color_r  <= color;
    end else if (cmd.step) begin
      px_r   <= px_step;
      py_r   <= py_step;
      err_r  <= err_nxt;
      left_r <= left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x_r       <= px_step;
      pixel_y_r       <= py_step;
      pixel_address_r <= frame_base_r + ADDR_W'({lin_idx, 2'b00});
      pixel_color_r   <= color_r;
      last_r          <= (left_r == CNT_W'(1));
    end
  end

  assign pixel_x       = pixel_x_r;
  assign pixel_y       = pixel_y_r;
  assign pixel_address = pixel_address_r;
  assign pixel_color   = pixel_color_r;
  assign last          = last_r;

  assign status.zero_len   = horiz & vert;
  assign status.last_pixel = (left_r == CNT_W'(1));

endmodule

// ----- rtl/lpg_ctrl.sv -----
module lpg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lpg_pkg::lpg_status_t status,
  output lpg_pkg::lpg_cmd_t    cmd
);
  import lpg_pkg::*;

  typedef enum logic {IDLE, WALK} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshake and commands
  always_comb begin
    in_ready = (state_r == IDLE);
    cmd.load = in_valid & in_ready;
    cmd.step = (state_r == WALK) & (~out_valid_r | out_ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      IDLE: if (cmd.load && !status.zero_len) state_nxt = WALK;
      WALK: if (cmd.step && status.last_pixel) state_nxt = IDLE;
      default: state_nxt = IDLE;
    endcase
    out_valid_nxt = cmd.step | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_load_while_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && out_valid_r |-> out_ready)
    else $error("pending result overwritten");

  a_zero_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && status.zero_len |=> state_r == IDLE && !cmd.step)
    else $error("zero length line started a walk");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && status.last_pixel |=> state_r == IDLE && out_valid_r)
    else $error("walk did not end after last pixel");
`endif

endmodule
